// ===== hdl/prpdd_pkg.sv =====
// ----------------------------------------------------------------------------
// prpdd_pkg
// shared types, constants and hash helper for the prp duplicate discard block
// ----------------------------------------------------------------------------
package prpdd_pkg;

	localparam int DefNodes         = 512;
	localparam int DefSeqSlots      = 64;
	localparam int DefProbes        = 20;
	localparam int DefHashExtraBits = 3;

	localparam logic [31:0] HashMult    = 32'h9E37_0001;
	localparam logic [15:0] TrailerType = 16'h88FB;

	localparam logic [3:0]  RstOwnLan   = 4'd10;
	localparam logic [3:0]  RstLanA     = 4'd10;
	localparam logic [3:0]  RstLanB     = 4'd11;
	localparam logic [15:0] RstWindow   = 16'd400;
	localparam logic [15:0] RstNodeAge  = 16'd5000;

	localparam logic [2:0] RegOwnLan  = 3'd0;
	localparam logic [2:0] RegLanA    = 3'd1;
	localparam logic [2:0] RegLanB    = 3'd2;
	localparam logic [2:0] RegWindow  = 3'd3;
	localparam logic [2:0] RegNodeAge = 3'd4;

	typedef enum logic [2:0] {
		VerdictAccept    = 3'd0,
		VerdictDuplicate = 3'd1,
		VerdictNoTrailer = 3'd2,
		VerdictUnknownLan = 3'd3,
		VerdictWrongLan  = 3'd4,
		VerdictSizeBad   = 3'd5,
		VerdictTableFull = 3'd6
	} verdict_t;

	typedef struct packed {
		logic [47:0] src_mac;
		logic [15:0] trailer_seq;
		logic [15:0] trailer_lan_size;
		logic [15:0] trailer_type;
		logic [15:0] frame_length;
		logic [15:0] header_length;
		logic [31:0] now_ms;
	} frame_in_t;

	typedef struct packed {
		logic [2:0] verdict;
		logic [8:0] node_slot;
	} result_t;

	typedef struct packed {
		logic [3:0]  own_lan_id;
		logic [3:0]  lan_id_a;
		logic [3:0]  lan_id_b;
		logic [15:0] discard_window_ms;
		logic [15:0] node_age_ms;
	} cfg_t;

	typedef enum logic [2:0] {
		StClear,
		StIdle,
		StProbe,
		StCheck,
		StSeqRead,
		StSeqWrite,
		StDone
	} state_t;

	// top bits of the product for a probe, full word once 32 are kept
	function automatic logic [31:0] probe_hash(input logic [31:0] prod, input logic [5:0] w);
		logic [31:0] r;
		r = prod;
		if (w < 6'd32)
			r = prod >> (6'd32 - w);
		return r;
	endfunction

endpackage

// ===== hdl/prp_trailer_duplicate_discard.sv =====
// ----------------------------------------------------------------------------
// prp_trailer_duplicate_discard
// prp receive duplicate discard: node lookup by open hashing, trailer checks
// and per node sequence slot timestamps
// ----------------------------------------------------------------------------
// steps: each node probe reads the entry, then decides; a check state follows,
//   then on a passing check a read-modify-write of the sequence stamp
//   (StSeqRead, StSeqWrite), and StDone registers the result strobe
// throughput: one frame at a time, busy stays high until the result strobe;
//   a new frame is taken only in idle, once the last one is through
// reset: after arst_n is released a clearing pass writes every node entry and
//   every sequence stamp, busy high
// the result strobe lasts one cycle and cannot be held off
module prp_trailer_duplicate_discard
	import prpdd_pkg::*;
#(
	parameter int NODES           = DefNodes,
	parameter int SEQ_SLOTS       = DefSeqSlots,
	parameter int PROBES          = DefProbes,
	parameter int HASH_EXTRA_BITS = DefHashExtraBits
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  frame_in_t   frame_in,
	output logic        result_valid,
	output result_t     result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int NW    = $clog2(NODES);
	localparam int SW    = $clog2(SEQ_SLOTS);
	localparam int DEPTH = NODES * SEQ_SLOTS;
	localparam int AW    = NW + SW;
	localparam int PW    = $clog2(PROBES + 1);
	localparam logic [5:0] BaseBits = 6'(NW + HASH_EXTRA_BITS);

	cfg_t cfg;

	prpdd_cfg_regs u_cfg (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
		.prdata, .pready, .cfg
	);

	state_t state_q, state_d;

	frame_in_t     frame_q;
	logic [31:0]   prod_q;          // key times hash multiplier
	logic [PW-1:0] probe_q;         // probe number under way
	logic [NW-1:0] slot_q;          // slot of the current probe / found node
	logic [AW-1:0] clr_q;           // clearing pass address
	logic [2:0]    verdict_q;
	logic          hit_q;

	// node memory ports
	logic          n_used, n_wr_en, n_wr_used;
	logic [47:0]   n_mac, n_wr_mac;
	logic [31:0]   n_stamp, n_wr_stamp;
	logic [NW-1:0] n_rd_addr, n_wr_addr;

	// sequence memory ports
	logic [AW-1:0] s_addr, s_wr_addr;
	logic [31:0]   s_rd_data, s_wr_data;
	logic          s_wr_en;

	prpdd_node_mem #(.NODES(NODES)) u_node (
		.clk, .rd_addr(n_rd_addr), .rd_used(n_used), .rd_mac(n_mac),
		.rd_stamp(n_stamp), .wr_en(n_wr_en), .wr_addr(n_wr_addr),
		.wr_used(n_wr_used), .wr_mac(n_wr_mac), .wr_stamp(n_wr_stamp)
	);

	prpdd_seq_mem #(.DEPTH(DEPTH)) u_seq (
		.clk, .rd_addr(s_addr), .rd_data(s_rd_data), .wr_en(s_wr_en),
		.wr_addr(s_wr_addr), .wr_data(s_wr_data)
	);

	// slot for a probe number taken from the registered product
	function automatic logic [NW-1:0] slot_of(input logic [31:0] p, input logic [PW-1:0] i);
		logic [31:0] h;
		h = probe_hash(p, BaseBits + 6'(i));
		return h[NW-1:0];
	endfunction

	// probe decision on the node entry read last cycle
	logic        same_mac, aged, take;
	logic [31:0] age_diff;
	assign age_diff = frame_q.now_ms - n_stamp;
	assign same_mac = n_mac == frame_q.src_mac;
	assign aged     = age_diff >= {16'd0, cfg.node_age_ms};
	assign take     = !n_used || same_mac || aged;

	logic last_probe;
	assign last_probe = probe_q == PW'(PROBES - 1);

	// trailer checks
	logic [3:0]  lan;
	logic [15:0] lsdu;
	logic [2:0]  check_verdict;
	logic [31:0] seq_diff;
	assign lan  = frame_q.trailer_lan_size[15:12];
	assign lsdu = frame_q.frame_length - frame_q.header_length;
	assign seq_diff = frame_q.now_ms - s_rd_data;

	always_comb begin
		if (frame_q.trailer_type != TrailerType)
			check_verdict = VerdictNoTrailer;
		else if (lan != cfg.lan_id_a && lan != cfg.lan_id_b)
			check_verdict = VerdictUnknownLan;
		else if (lan != cfg.own_lan_id)
			check_verdict = VerdictWrongLan;
		else if (lsdu != {4'd0, frame_q.trailer_lan_size[11:0]})
			check_verdict = VerdictSizeBad;
		else
			check_verdict = VerdictAccept;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			StClear:    if (clr_q == AW'(DEPTH - 1)) state_d = StIdle;
			StIdle:     if (start) state_d = StProbe;
			StProbe:    if (hit_q) begin
					if (take) state_d = StCheck;
					else if (last_probe) state_d = StDone;
				end
			StCheck:    state_d = (check_verdict == VerdictAccept) ? StSeqRead : StDone;
			StSeqRead:  state_d = StSeqWrite;
			StSeqWrite: state_d = StDone;
			StDone:     state_d = StIdle;
			default:    state_d = StIdle;
		endcase
	end

	// memory controls and outputs
	always_comb begin
		n_rd_addr  = slot_q;
		n_wr_en    = 1'b0;
		n_wr_addr  = slot_q;
		n_wr_used  = 1'b1;
		n_wr_mac   = frame_q.src_mac;
		n_wr_stamp = n_stamp;
		s_addr     = {slot_q, frame_q.trailer_seq[SW-1:0]};
		s_wr_en    = 1'b0;
		s_wr_addr  = s_addr;
		s_wr_data  = frame_q.now_ms;
		case (state_q)
			StClear: begin
				n_wr_en    = clr_q < AW'(NODES);
				n_wr_addr  = clr_q[NW-1:0];
				n_wr_used  = 1'b0;
				n_wr_mac   = 48'd0;
				n_wr_stamp = 32'd0;
				s_wr_en    = 1'b1;
				s_wr_addr  = clr_q;
				s_wr_data  = 32'd0;
			end
			StProbe: begin
				// first probe reads straight from the product, slot_q not yet loaded
				if (!hit_q && probe_q == '0)
					n_rd_addr = slot_of(prod_q, '0);
				// write back on a free claim or a takeover
				if (hit_q && take && !(n_used && same_mac)) begin
					n_wr_en = 1'b1;
					if (n_used) n_wr_stamp = frame_q.now_ms;
				end
			end
			StSeqWrite: s_wr_en = 1'b1;
			default: ;
		endcase
	end

	assign busy = state_q != StIdle;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= StClear;
			clr_q        <= '0;
			probe_q      <= '0;
			hit_q        <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			state_q      <= state_d;
			result_valid <= 1'b0;
			case (state_q)
				StClear: clr_q <= clr_q + AW'(1);
				StIdle: if (start) begin
					probe_q <= '0;
					hit_q   <= 1'b0;
				end
				StProbe: begin
					// each probe issues the read, then decides on the returned entry
					hit_q <= !hit_q;
					if (hit_q && !take && !last_probe)
						probe_q <= probe_q + PW'(1);
				end
				StDone: result_valid <= 1'b1;
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			StIdle: if (start) begin
				frame_q   <= frame_in;
				prod_q    <= frame_in.src_mac[31:0] * HashMult;
			end
			StProbe: begin
				if (!hit_q && probe_q == '0)
					slot_q <= slot_of(prod_q, '0);
				if (hit_q && !take && !last_probe)
					slot_q <= slot_of(prod_q, probe_q + PW'(1));
				if (hit_q && !take && last_probe)
					verdict_q <= VerdictTableFull;
			end
			StCheck:    verdict_q <= check_verdict;
			StSeqWrite: verdict_q <= (seq_diff < {16'd0, cfg.discard_window_ms}) ?
				VerdictDuplicate : VerdictAccept;
			default: ;
		endcase
	end

	assign result.verdict   = verdict_q;
	assign result.node_slot = (verdict_q == VerdictTableFull) ? 9'd0 : 9'(slot_q);

endmodule

// ===== hdl/prpdd_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// prpdd_cfg_regs
// apb register file holding the lan ids, discard window and node age
// ----------------------------------------------------------------------------
module prpdd_cfg_regs
	import prpdd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	logic [2:0] reg_idx;
	logic       wr_en;
	assign reg_idx = paddr[4:2];
	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.own_lan_id        <= RstOwnLan;
			cfg.lan_id_a          <= RstLanA;
			cfg.lan_id_b          <= RstLanB;
			cfg.discard_window_ms <= RstWindow;
			cfg.node_age_ms       <= RstNodeAge;
		end else if (wr_en) begin
			case (reg_idx)
				RegOwnLan:  cfg.own_lan_id        <= pwdata[3:0];
				RegLanA:    cfg.lan_id_a          <= pwdata[3:0];
				RegLanB:    cfg.lan_id_b          <= pwdata[3:0];
				RegWindow:  cfg.discard_window_ms <= pwdata[15:0];
				RegNodeAge: cfg.node_age_ms       <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			RegOwnLan:  prdata = {28'd0, cfg.own_lan_id};
			RegLanA:    prdata = {28'd0, cfg.lan_id_a};
			RegLanB:    prdata = {28'd0, cfg.lan_id_b};
			RegWindow:  prdata = {16'd0, cfg.discard_window_ms};
			RegNodeAge: prdata = {16'd0, cfg.node_age_ms};
			default:    prdata = 32'd0;
		endcase
	end

endmodule

// ===== hdl/prpdd_node_mem.sv =====
// ----------------------------------------------------------------------------
// prpdd_node_mem
// node table memory: used flag, mac and age stamp per slot, registered read
// ----------------------------------------------------------------------------
module prpdd_node_mem
	import prpdd_pkg::*;
#(
	parameter int NODES = DefNodes,
	localparam int NW = $clog2(NODES)
) (
	input  logic          clk,
	input  logic [NW-1:0] rd_addr,
	output logic          rd_used,
	output logic [47:0]   rd_mac,
	output logic [31:0]   rd_stamp,
	input  logic          wr_en,
	input  logic [NW-1:0] wr_addr,
	input  logic          wr_used,
	input  logic [47:0]   wr_mac,
	input  logic [31:0]   wr_stamp
);

	logic [80:0] mem [NODES];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= {wr_used, wr_mac, wr_stamp};
		{rd_used, rd_mac, rd_stamp} <= mem[rd_addr];
	end

endmodule

// ===== hdl/prpdd_seq_mem.sv =====
// ----------------------------------------------------------------------------
// prpdd_seq_mem
// per node, per sequence slot timestamp memory, registered read
// ----------------------------------------------------------------------------
module prpdd_seq_mem
	import prpdd_pkg::*;
#(
	parameter int DEPTH = DefNodes * DefSeqSlots,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic [AW-1:0] rd_addr,
	output logic [31:0]   rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [31:0]   wr_data
);

	logic [31:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		rd_data <= mem[rd_addr];
	end

endmodule

// ===== hdl/prpdd_checker.sv =====
// ----------------------------------------------------------------------------
// prpdd_checker
// port level checks for the prp duplicate discard block
// ----------------------------------------------------------------------------
module prpdd_checker
	import prpdd_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    start,
	input logic    busy,
	input logic    result_valid,
	input result_t result,
	input logic    pready
);

	a_strobe_single: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid) else $error("result strobe longer than one cycle");

	a_idle_during_result: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !busy) else $error("result strobe while busy");

	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("frame transfer did not raise busy");

	a_full_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.verdict == VerdictTableFull) |-> result.node_slot == 9'd0)
		else $error("table full with nonzero slot");

	a_verdict_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.verdict != 3'd7 && pready))
		else $error("verdict code out of range");

endmodule

bind prp_trailer_duplicate_discard prpdd_checker u_prpdd_checker (
	.clk, .arst_n, .start, .busy, .result_valid, .result, .pready
);
